// ===== hw/rtl/pom_pkg.sv =====
package pom_pkg;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [16:0] ONE_Q16      = 17'd65536;
    localparam logic [16:0] HALF_Q16     = 17'd32768;
    localparam logic [16:0] VIEW_Z_FLOOR = 17'd5243;
    localparam logic [16:0] ROUND_Q16    = 17'd65535;

    localparam logic [7:0] MAX_LAYERS_BOUND = 8'd128;
    localparam logic [3:0] MAX_REFINE_BOUND = 4'd12;

    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_Q_W   = 20;

    localparam int SQRT_IN_W  = 36;
    localparam int SQRT_OUT_W = 18;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic OP_START     = 1'b0;
    localparam logic OP_HEIGHT    = 1'b1;
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_FINAL   = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_OFFSET,
        PH_MARCH,
        PH_REFINE
    } phase_t;

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_OFFSET,
        MODE_STEEP,
        MODE_OCCLUSION
    } mode_t;

    typedef enum logic [2:0] {
        REG_HEIGHT_MODE,
        REG_HEIGHT_SCALE,
        REG_REFERENCE_PLANE,
        REG_MIN_LAYERS,
        REG_MAX_LAYERS,
        REG_REFINE_COUNT,
        REG_MAX_DISTANCE
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_SUM,
        ST_NORM_CHK,
        ST_SQRT,
        ST_DIV_Z,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DIV_FADE,
        ST_DIV_MX,
        ST_MUL_SX,
        ST_MUL_FX,
        ST_DIV_MY,
        ST_MUL_SY,
        ST_MUL_FY,
        ST_DIR,
        ST_MUL_STEPS,
        ST_STEPS,
        ST_DIV_LSTEP,
        ST_DIV_SDX,
        ST_DIV_SDY,
        ST_RESP,
        ST_OFF_MU,
        ST_OFF_MV,
        ST_OFF_FIN,
        ST_REFINE_NEXT,
        ST_EMIT
    } seq_state_t;

endpackage

// ===== hw/rtl/pom_div.sv =====
module pom_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pom_pkg::DIV_NUM_W-1:0]  dividend,
    input  logic [pom_pkg::DIV_DEN_W-1:0]  divisor,
    output logic                           done,
    output logic [pom_pkg::DIV_Q_W-1:0]    quotient
);
    import pom_pkg::*;

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_Q_W-1:0]   q_reg, q_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    // quotient known to fit DIV_Q_W bits: upper dividend bits start as remainder
    always_comb
    begin
        trial     = {rem_reg, q_reg[DIV_Q_W-1]};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_Q_W);
            rem_next  = DIV_DEN_W'(dividend[DIV_NUM_W-1:DIV_Q_W]);
            q_next    = dividend[DIV_Q_W-1:0];
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            q_next   = {q_reg[DIV_Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hw/rtl/pom_sqrt.sv =====
module pom_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pom_pkg::SQRT_IN_W-1:0]   radicand,
    output logic                            done,
    output logic [pom_pkg::SQRT_OUT_W-1:0]  root
);
    import pom_pkg::*;

    localparam int CNT_W = $clog2(SQRT_OUT_W + 1);
    localparam int REM_W = SQRT_OUT_W + 2;
    localparam int T_W   = REM_W + 2;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SQRT_IN_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [SQRT_OUT_W-1:0] root_reg, root_next;
    logic [T_W-1:0]        t;
    logic [T_W-1:0]        trial;
    logic                  ge;

    always_comb
    begin
        t         = {rem_reg, rad_reg[SQRT_IN_W-1:SQRT_IN_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = (t >= trial);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SQRT_OUT_W);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? REM_W'(t - trial) : t[REM_W-1:0];
            root_next = {root_reg[SQRT_OUT_W-2:0], ge};
            rad_next  = {rad_reg[SQRT_IN_W-3:0], 2'b00};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/parallax_occlusion_uv_offset_unit.sv =====
// Start transaction: runs on the 20-bit shared restoring divider (up to nine uses)
// and the serial square root; off or out of range goes straight to the result.
// Height response transaction: ST_RESP in march and refine; ST_OFF_MU, ST_OFF_MV
// and ST_OFF_FIN in offset mode.
// One transaction in flight; input is taken again while the last result waits.
// rst_n clears the sequencer, phase, output valid and the registers to their defaults.
module parallax_occlusion_uv_offset_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pom_pkg::APB_AW-1:0]   paddr,
    input  logic [pom_pkg::APB_DW-1:0]   pwdata,
    output logic [pom_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic signed [31:0]           start_u,
    input  logic signed [31:0]           start_v,
    input  logic signed [15:0]           view_x,
    input  logic signed [15:0]           view_y,
    input  logic signed [15:0]           view_z,
    input  logic [31:0]                  camera_distance,
    input  logic [16:0]                  height,
    input  logic                         height_valid,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic signed [31:0]           out_u,
    output logic signed [31:0]           out_v,
    output logic [7:0]                   sample_total
);
    import pom_pkg::*;

    // configuration
    mode_t       mode_reg;
    logic [16:0] scale_reg, refp_reg;
    logic [7:0]  minl_reg, maxl_reg;
    logic [3:0]  refc_reg;
    logic [31:0] maxd_reg;
    reg_idx_t    cfg_idx;
    logic        cfg_wr;

    // sequencer and model state
    seq_state_t  state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic        launched_reg, launched_next;
    logic [31:0] cur_u_reg, cur_u_next, cur_v_reg, cur_v_next;
    logic [31:0] prev_u_reg, prev_u_next, prev_v_reg, prev_v_next;
    logic [31:0] sd_u_reg, sd_u_next, sd_v_reg, sd_v_next;
    logic [16:0] cur_d_reg, cur_d_next, prev_d_reg, prev_d_next;
    logic [16:0] lstep_reg, lstep_next;
    logic [7:0]  ltotal_reg, ltotal_next, samples_reg, samples_next;
    logic [3:0]  rdone_reg, rdone_next;

    // work registers
    logic [15:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic        xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic [31:0] dist_reg, dist_next, lsq_reg, lsq_next;
    logic [17:0] len_reg, len_next;
    logic [16:0] nz_reg, nz_next, nx_reg, nx_next, ny_reg, ny_next;
    logic [16:0] fade_reg, fade_next, h_reg, h_next;
    logic [19:0] m_reg, m_next, dirx_reg, dirx_next, diry_reg, diry_next;
    logic [7:0]  steps_reg, steps_next;
    logic        res_kind_reg, res_kind_next;
    logic [31:0] res_u_reg, res_u_next, res_v_reg, res_v_next;
    logic [7:0]  res_n_reg, res_n_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [31:0] out_u_reg, out_v_reg;
    logic [7:0]  out_n_reg;

    // shared units
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 mul_en;
    logic [MUL_P_W-1:0]   prod_reg;
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_Q_W-1:0]   div_q;
    logic                 sqrt_start, sqrt_done;
    logic [SQRT_OUT_W-1:0] sqrt_root;

    // derived values
    logic        in_accept, off_hit, out_free, march_adv, unit_done;
    logic [16:0] scale_sat, ref_sat, h_in, vz, q_sat;
    logic [7:0]  lo, hi, hi_lo;
    logic [3:0]  rc_sat;
    logic [17:0] diff;
    logic [16:0] diff_mag;
    logic [31:0] sdu_mag, sdv_mag, t32;
    logic [32:0] mu_sum, mv_sum;
    logic [31:0] mu, mv;
    logic [17:0] md_sum;
    logic [16:0] md;
    logic [23:0] steps_round;

    pom_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    pom_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({lsq_reg, 4'b0000}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // APB
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_HEIGHT_MODE:     prdata = {30'd0, mode_reg};
            REG_HEIGHT_SCALE:    prdata = {15'd0, scale_reg};
            REG_REFERENCE_PLANE: prdata = {15'd0, refp_reg};
            REG_MIN_LAYERS:      prdata = {24'd0, minl_reg};
            REG_MAX_LAYERS:      prdata = {24'd0, maxl_reg};
            REG_REFINE_COUNT:    prdata = {28'd0, refc_reg};
            REG_MAX_DISTANCE:    prdata = maxd_reg;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OFF;
            scale_reg <= 17'd0;
            refp_reg  <= 17'd32768;
            minl_reg  <= 8'd8;
            maxl_reg  <= 8'd32;
            refc_reg  <= 4'd5;
            maxd_reg  <= 32'd1310720;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_HEIGHT_MODE:     mode_reg  <= mode_t'(pwdata[1:0]);
                REG_HEIGHT_SCALE:    scale_reg <= pwdata[16:0];
                REG_REFERENCE_PLANE: refp_reg  <= pwdata[16:0];
                REG_MIN_LAYERS:      minl_reg  <= pwdata[7:0];
                REG_MAX_LAYERS:      maxl_reg  <= pwdata[7:0];
                REG_REFINE_COUNT:    refc_reg  <= pwdata[3:0];
                REG_MAX_DISTANCE:    maxd_reg  <= pwdata;
                default:             ;
            endcase
        end
    end

    // derived
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign off_hit   = (mode_reg == MODE_OFF) || (scale_reg == 17'd0)
                       || (camera_distance >= maxd_reg);
    assign scale_sat = (scale_reg > ONE_Q16) ? ONE_Q16 : scale_reg;
    assign ref_sat   = (refp_reg > ONE_Q16) ? ONE_Q16 : refp_reg;
    assign h_in      = height_valid ? ((height > ONE_Q16) ? ONE_Q16 : height) : HALF_Q16;
    assign vz        = (nz_reg > VIEW_Z_FLOOR) ? nz_reg : VIEW_Z_FLOOR;
    assign q_sat     = (div_q > DIV_Q_W'(ONE_Q16)) ? ONE_Q16 : div_q[16:0];
    assign rc_sat    = (refc_reg > MAX_REFINE_BOUND) ? MAX_REFINE_BOUND : refc_reg;
    assign unit_done = launched_reg && (div_done || sqrt_done);

    always_comb
    begin
        lo = (minl_reg == 8'd0) ? 8'd1 : minl_reg;
        if (lo > MAX_LAYERS_BOUND)
        begin
            lo = MAX_LAYERS_BOUND;
        end
        hi = (maxl_reg < lo) ? lo : maxl_reg;
        if (hi > MAX_LAYERS_BOUND)
        begin
            hi = MAX_LAYERS_BOUND;
        end
        hi_lo = hi - lo;
    end

    assign diff      = {1'b0, h_reg} - {1'b0, ref_sat};
    assign diff_mag  = diff[17] ? 17'(-diff) : diff[16:0];
    assign sdu_mag   = sd_u_reg[31] ? -sd_u_reg : sd_u_reg;
    assign sdv_mag   = sd_v_reg[31] ? -sd_v_reg : sd_v_reg;
    assign t32       = prod_reg[47:16];
    assign mu_sum    = {prev_u_reg[31], prev_u_reg} + {cur_u_reg[31], cur_u_reg};
    assign mv_sum    = {prev_v_reg[31], prev_v_reg} + {cur_v_reg[31], cur_v_reg};
    assign mu        = mu_sum[32:1];
    assign mv        = mv_sum[32:1];
    assign md_sum    = {1'b0, prev_d_reg} + {1'b0, cur_d_reg};
    assign md        = md_sum[17:1];
    assign march_adv = (cur_d_reg < h_reg) && (samples_reg < ltotal_reg);
    assign steps_round = prod_reg[23:0] + 24'(ROUND_Q16);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == OP_START)
                    begin
                        state_next = off_hit ? ST_EMIT : ST_SQ_X;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_OFFSET: state_next = ST_OFF_MU;
                            PH_MARCH:  state_next = ST_RESP;
                            PH_REFINE: state_next = ST_RESP;
                            default:   state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_SQ_X:      state_next = ST_SQ_Y;
            ST_SQ_Y:      state_next = ST_SQ_Z;
            ST_SQ_Z:      state_next = ST_SQ_SUM;
            ST_SQ_SUM:    state_next = ST_NORM_CHK;
            ST_NORM_CHK:  state_next = (lsq_reg == 32'd0) ? ST_DIV_FADE : ST_SQRT;
            ST_SQRT:      state_next = unit_done ? ST_DIV_Z : ST_SQRT;
            ST_DIV_Z:     state_next = unit_done ? ST_DIV_X : ST_DIV_Z;
            ST_DIV_X:     state_next = unit_done ? ST_DIV_Y : ST_DIV_X;
            ST_DIV_Y:     state_next = unit_done ? ST_DIV_FADE : ST_DIV_Y;
            ST_DIV_FADE:  state_next = unit_done ? ST_DIV_MX : ST_DIV_FADE;
            ST_DIV_MX:    state_next = unit_done ? ST_MUL_SX : ST_DIV_MX;
            ST_MUL_SX:    state_next = ST_MUL_FX;
            ST_MUL_FX:    state_next = ST_DIV_MY;
            ST_DIV_MY:    state_next = unit_done ? ST_MUL_SY : ST_DIV_MY;
            ST_MUL_SY:    state_next = ST_MUL_FY;
            ST_MUL_FY:    state_next = ST_DIR;
            ST_DIR:       state_next = (mode_reg == MODE_OFFSET) ? ST_EMIT : ST_MUL_STEPS;
            ST_MUL_STEPS: state_next = ST_STEPS;
            ST_STEPS:     state_next = ST_DIV_LSTEP;
            ST_DIV_LSTEP: state_next = unit_done ? ST_DIV_SDX : ST_DIV_LSTEP;
            ST_DIV_SDX:   state_next = unit_done ? ST_DIV_SDY : ST_DIV_SDX;
            ST_DIV_SDY:   state_next = unit_done ? ST_EMIT : ST_DIV_SDY;
            ST_RESP:
            begin
                if (phase_reg == PH_MARCH && (march_adv || mode_reg != MODE_OCCLUSION))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_REFINE_NEXT;
                end
            end
            ST_OFF_MU:      state_next = ST_OFF_MV;
            ST_OFF_MV:      state_next = ST_OFF_FIN;
            ST_OFF_FIN:     state_next = ST_EMIT;
            ST_REFINE_NEXT: state_next = ST_EMIT;
            ST_EMIT:        state_next = out_free ? ST_IDLE : ST_EMIT;
            default:        state_next = ST_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb
    begin
        phase_next    = phase_reg;
        launched_next = launched_reg;
        cur_u_next    = cur_u_reg;
        cur_v_next    = cur_v_reg;
        prev_u_next   = prev_u_reg;
        prev_v_next   = prev_v_reg;
        sd_u_next     = sd_u_reg;
        sd_v_next     = sd_v_reg;
        cur_d_next    = cur_d_reg;
        prev_d_next   = prev_d_reg;
        lstep_next    = lstep_reg;
        ltotal_next   = ltotal_reg;
        samples_next  = samples_reg;
        rdone_next    = rdone_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        az_next       = az_reg;
        xneg_next     = xneg_reg;
        yneg_next     = yneg_reg;
        dist_next     = dist_reg;
        lsq_next      = lsq_reg;
        len_next      = len_reg;
        nz_next       = nz_reg;
        nx_next       = nx_reg;
        ny_next       = ny_reg;
        fade_next     = fade_reg;
        h_next        = h_reg;
        m_next        = m_reg;
        dirx_next     = dirx_reg;
        diry_next     = diry_reg;
        steps_next    = steps_reg;
        res_kind_next = res_kind_reg;
        res_u_next    = res_u_reg;
        res_v_next    = res_v_reg;
        res_n_next    = res_n_reg;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;
        div_num       = '0;
        div_den       = '0;
        sqrt_start    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && op == OP_START)
                begin
                    res_u_next = start_u;
                    res_v_next = start_v;
                    if (off_hit)
                    begin
                        phase_next    = PH_IDLE;
                        res_kind_next = KIND_FINAL;
                        res_n_next    = 8'd0;
                    end
                    else
                    begin
                        cur_u_next    = start_u;
                        cur_v_next    = start_v;
                        prev_u_next   = start_u;
                        prev_v_next   = start_v;
                        cur_d_next    = '0;
                        prev_d_next   = '0;
                        rdone_next    = '0;
                        samples_next  = 8'd1;
                        res_kind_next = KIND_REQUEST;
                        res_n_next    = 8'd1;
                        ax_next       = view_x[15] ? 16'(-view_x) : 16'(view_x);
                        ay_next       = view_y[15] ? 16'(-view_y) : 16'(view_y);
                        az_next       = view_z[15] ? 16'(-view_z) : 16'(view_z);
                        xneg_next     = view_x[15];
                        yneg_next     = view_y[15];
                        dist_next     = camera_distance;
                    end
                end
                else if (in_accept)
                begin
                    h_next = h_in;
                end
            end
            ST_SQ_X:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(ax_reg);
                mul_b  = MUL_B_W'(ax_reg);
            end
            ST_SQ_Y:
            begin
                mul_en   = 1'b1;
                mul_a    = MUL_A_W'(ay_reg);
                mul_b    = MUL_B_W'(ay_reg);
                lsq_next = prod_reg[31:0];
            end
            ST_SQ_Z:
            begin
                mul_en   = 1'b1;
                mul_a    = MUL_A_W'(az_reg);
                mul_b    = MUL_B_W'(az_reg);
                lsq_next = lsq_reg + prod_reg[31:0];
            end
            ST_SQ_SUM:
            begin
                lsq_next = lsq_reg + prod_reg[31:0];
            end
            ST_NORM_CHK:
            begin
                if (lsq_reg == 32'd0)
                begin
                    nz_next = ONE_Q16;
                    nx_next = '0;
                    ny_next = '0;
                end
            end
            ST_SQRT:
            begin
                if (!launched_reg)
                begin
                    sqrt_start    = 1'b1;
                    launched_next = 1'b1;
                end
                else if (sqrt_done)
                begin
                    len_next      = sqrt_root;
                    launched_next = 1'b0;
                end
            end
            ST_DIV_Z, ST_DIV_X, ST_DIV_Y:
            begin
                div_den = DIV_DEN_W'(len_reg);
                unique case (state_reg)
                    ST_DIV_Z: div_num = {14'd0, az_reg, 18'd0};
                    ST_DIV_X: div_num = {14'd0, ax_reg, 18'd0};
                    default:  div_num = {14'd0, ay_reg, 18'd0};
                endcase
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    unique case (state_reg)
                        ST_DIV_Z: nz_next = q_sat;
                        ST_DIV_X: nx_next = q_sat;
                        default:  ny_next = q_sat;
                    endcase
                end
            end
            ST_DIV_FADE:
            begin
                div_num = {maxd_reg - dist_reg, 16'd0};
                div_den = maxd_reg;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    fade_next     = div_q[16:0];
                end
            end
            ST_DIV_MX, ST_DIV_MY:
            begin
                div_num = (state_reg == ST_DIV_MX) ? {15'd0, nx_reg, 16'd0}
                                                   : {15'd0, ny_reg, 16'd0};
                div_den = DIV_DEN_W'(vz);
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                    if (state_reg == ST_DIV_MY)
                    begin
                        dirx_next = prod_reg[35:16];
                    end
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    m_next        = div_q;
                end
            end
            ST_MUL_SX, ST_MUL_SY:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(m_reg);
                mul_b  = scale_sat;
            end
            ST_MUL_FX, ST_MUL_FY:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(prod_reg[35:16]);
                mul_b  = fade_reg;
            end
            ST_DIR:
            begin
                diry_next = prod_reg[35:16];
                if (mode_reg == MODE_OFFSET)
                begin
                    sd_u_next   = xneg_reg ? -{12'd0, dirx_reg} : {12'd0, dirx_reg};
                    sd_v_next   = yneg_reg ? -{12'd0, prod_reg[35:16]}
                                           : {12'd0, prod_reg[35:16]};
                    lstep_next  = '0;
                    ltotal_next = '0;
                    phase_next  = PH_OFFSET;
                end
            end
            ST_MUL_STEPS:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(hi_lo);
                mul_b  = ONE_Q16 - nz_reg;
            end
            ST_STEPS:
            begin
                steps_next  = lo + steps_round[23:16];
                ltotal_next = lo + steps_round[23:16];
            end
            ST_DIV_LSTEP, ST_DIV_SDX, ST_DIV_SDY:
            begin
                div_den = DIV_DEN_W'(steps_reg);
                unique case (state_reg)
                    ST_DIV_LSTEP: div_num = DIV_NUM_W'(ONE_Q16);
                    ST_DIV_SDX:   div_num = DIV_NUM_W'(dirx_reg);
                    default:      div_num = DIV_NUM_W'(diry_reg);
                endcase
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    unique case (state_reg)
                        ST_DIV_LSTEP: lstep_next = div_q[16:0];
                        ST_DIV_SDX:
                            sd_u_next = xneg_reg ? -{12'd0, div_q} : {12'd0, div_q};
                        default:
                        begin
                            sd_v_next  = yneg_reg ? -{12'd0, div_q} : {12'd0, div_q};
                            phase_next = PH_MARCH;
                        end
                    endcase
                end
            end
            ST_RESP:
            begin
                if (phase_reg == PH_MARCH)
                begin
                    if (march_adv)
                    begin
                        prev_u_next   = cur_u_reg;
                        prev_v_next   = cur_v_reg;
                        prev_d_next   = cur_d_reg;
                        cur_u_next    = cur_u_reg - sd_u_reg;
                        cur_v_next    = cur_v_reg - sd_v_reg;
                        cur_d_next    = cur_d_reg + lstep_reg;
                        samples_next  = samples_reg + 8'd1;
                        res_kind_next = KIND_REQUEST;
                        res_u_next    = cur_u_reg - sd_u_reg;
                        res_v_next    = cur_v_reg - sd_v_reg;
                        res_n_next    = samples_reg + 8'd1;
                    end
                    else if (mode_reg != MODE_OCCLUSION)
                    begin
                        phase_next    = PH_IDLE;
                        res_kind_next = KIND_FINAL;
                        res_u_next    = cur_u_reg;
                        res_v_next    = cur_v_reg;
                        res_n_next    = samples_reg;
                    end
                    else
                    begin
                        rdone_next = '0;
                    end
                end
                else
                begin
                    if (md < h_reg)
                    begin
                        prev_u_next = mu;
                        prev_v_next = mv;
                        prev_d_next = md;
                    end
                    else
                    begin
                        cur_u_next = mu;
                        cur_v_next = mv;
                        cur_d_next = md;
                    end
                    rdone_next = rdone_reg + 4'd1;
                end
            end
            ST_OFF_MU:
            begin
                mul_en = 1'b1;
                mul_a  = sdu_mag;
                mul_b  = diff_mag;
            end
            ST_OFF_MV:
            begin
                mul_en     = 1'b1;
                mul_a      = sdv_mag;
                mul_b      = diff_mag;
                res_u_next = (sd_u_reg[31] != diff[17]) ? cur_u_reg + t32 : cur_u_reg - t32;
            end
            ST_OFF_FIN:
            begin
                res_v_next    = (sd_v_reg[31] != diff[17]) ? cur_v_reg + t32 : cur_v_reg - t32;
                res_kind_next = KIND_FINAL;
                res_n_next    = samples_reg;
                phase_next    = PH_IDLE;
            end
            ST_REFINE_NEXT:
            begin
                res_u_next = mu;
                res_v_next = mv;
                if (rdone_reg >= rc_sat)
                begin
                    phase_next    = PH_IDLE;
                    res_kind_next = KIND_FINAL;
                    res_n_next    = samples_reg;
                end
                else
                begin
                    phase_next    = PH_REFINE;
                    samples_next  = samples_reg + 8'd1;
                    res_kind_next = KIND_REQUEST;
                    res_n_next    = samples_reg + 8'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_EMIT && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_u_reg    <= cur_u_next;
        cur_v_reg    <= cur_v_next;
        prev_u_reg   <= prev_u_next;
        prev_v_reg   <= prev_v_next;
        sd_u_reg     <= sd_u_next;
        sd_v_reg     <= sd_v_next;
        cur_d_reg    <= cur_d_next;
        prev_d_reg   <= prev_d_next;
        lstep_reg    <= lstep_next;
        ltotal_reg   <= ltotal_next;
        samples_reg  <= samples_next;
        rdone_reg    <= rdone_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        az_reg       <= az_next;
        xneg_reg     <= xneg_next;
        yneg_reg     <= yneg_next;
        dist_reg     <= dist_next;
        lsq_reg      <= lsq_next;
        len_reg      <= len_next;
        nz_reg       <= nz_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        fade_reg     <= fade_next;
        h_reg        <= h_next;
        m_reg        <= m_next;
        dirx_reg     <= dirx_next;
        diry_reg     <= diry_next;
        steps_reg    <= steps_next;
        res_kind_reg <= res_kind_next;
        res_u_reg    <= res_u_next;
        res_v_reg    <= res_v_next;
        res_n_reg    <= res_n_next;
        if (mul_en)
        begin
            prod_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            kind_reg  <= res_kind_reg;
            out_u_reg <= res_u_reg;
            out_v_reg <= res_v_reg;
            out_n_reg <= res_n_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_u        = out_u_reg;
    assign out_v        = out_v_reg;
    assign sample_total = out_n_reg;

    a_final_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && res_kind_reg == KIND_FINAL) |-> phase_reg == PH_IDLE)
        else $error("final result while a pixel is still open");

    a_refine_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_REFINE) |-> rdone_reg <= MAX_REFINE_BOUND)
        else $error("refinement count beyond bound");

    a_idle_response_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op == OP_HEIGHT && phase_reg == PH_IDLE) |=> state_reg == ST_IDLE)
        else $error("response with no open pixel produced work");

    a_march_has_layers: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MARCH) |-> ltotal_reg != 8'd0)
        else $error("march without layers");

endmodule
